// ===== hdl/ptlr_pkg.sv =====
// Shared types, constants and address/pixel functions for the tile line renderer.
package ptlr_pkg;

   localparam int VRAM_BYTES  = 131072;
   localparam int VRAM_ADDR_W = $clog2(VRAM_BYTES);
   localparam int ADDR_W      = 17;
   localparam int IN_DATA_W   = 48;
   localparam int OUT_DATA_W  = 48;

   localparam logic [ADDR_W-1:0] BASE_HIGH = 17'h1e000;
   localparam logic [ADDR_W-1:0] COL_KEEP  = 17'b11110000000111111;
   localparam logic [ADDR_W-1:0] COL_SEL   = 17'b00001111111000000;
   localparam logic [ADDR_W-1:0] PAT_KEEP  = 17'b11110011111111111;
   localparam logic [ADDR_W-1:0] PAT_SEL   = 17'b00001100000000000;

   localparam logic MODE_STORE  = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic CSR_COLOR_BASE   = 1'b0;
   localparam logic CSR_PATTERN_BASE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic store;
      logic load;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic line_last;
   } status_type;

   function automatic logic [ADDR_W-1:0] table_addr(
      input logic [ADDR_W-1:0] base,
      input logic [ADDR_W-1:0] keep,
      input logic [ADDR_W-1:0] sel,
      input logic [1:0]        third,
      input logic [7:0]        code
   );
      logic [ADDR_W-1:0] sum;
      sum = (base & BASE_HIGH) + {4'b0, third, 11'b0} + {6'b0, code, 3'b0};
      return sum & (keep | (base & sel));
   endfunction

   // pattern bit 7 is the leftmost pixel, landing in bits 31:28
   function automatic logic [31:0] expand_row(
      input logic [7:0] pat,
      input logic [7:0] clr
   );
      logic [31:0] px;
      for (int i = 0; i < 8; i++) begin
         px[4*i +: 4] = pat[i] ? clr[7:4] : clr[3:0];
      end
      return px;
   endfunction

endpackage

// ===== hdl/ptlr_ctrl.sv =====
// Controller state machine: accepts words and sequences the eight line reads.
module ptlr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   input  ptlr_pkg::status_type  status,
   output ptlr_pkg::cmd_type     cmd
);
   import ptlr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == MODE_RENDER) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.slot_free && status.line_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.store  = accept && (req_tuser == MODE_STORE);
            cmd.load   = accept && (req_tuser == MODE_RENDER);
         end
         ST_RUN: begin
            cmd.issue = status.slot_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/ptlr_dp.sv =====
// Datapath: video memory, table registers, address and line counters, output word.
module ptlr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [ptlr_pkg::ADDR_W-1:0]        csr_wdata,
   input  logic [ptlr_pkg::IN_DATA_W-1:0]     req_tdata,
   input  ptlr_pkg::cmd_type                  cmd,
   output ptlr_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptlr_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import ptlr_pkg::*;

   logic [7:0] vram_mem [VRAM_BYTES];

   logic [ADDR_W-1:0] cbase_ff, pbase_ff;
   logic [ADDR_W-1:0] caddr_ff, paddr_ff;
   logic [ADDR_W-1:0] caddr_in, paddr_in;
   logic [2:0]        line_ff, line_in;
   logic [4:0]        row_ff, col_ff;
   logic [7:0]        pat_ff, clr_ff;
   logic [7:0]        out_row_ff;
   logic [7:0]        out_col_ff;
   logic              out_last_ff;
   logic              valid_ff, valid_in;

   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_byte;
   logic [9:0]        name_offset;
   logic [7:0]        char_code;
   logic [ADDR_W-1:0] prd_addr, crd_addr;

   assign wr_addr     = req_tdata[16:0];
   assign wr_byte     = req_tdata[24:17];
   assign name_offset = req_tdata[34:25];
   assign char_code   = req_tdata[42:35];

   assign caddr_in = table_addr(cbase_ff, COL_KEEP, COL_SEL, name_offset[9:8], char_code);
   assign paddr_in = table_addr(pbase_ff, PAT_KEEP, PAT_SEL, name_offset[9:8], char_code);

   assign prd_addr = paddr_ff + {14'b0, line_ff};
   assign crd_addr = caddr_ff + {14'b0, line_ff};

   assign status.slot_free = !valid_ff || rsp_tready;
   assign status.line_last = (line_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         cbase_ff <= '0;
         pbase_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLOR_BASE:   cbase_ff <= csr_wdata;
            CSR_PATTERN_BASE: pbase_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      line_in = line_ff;
      if (cmd.load) begin
         line_in = 3'd0;
      end else if (cmd.issue) begin
         line_in = line_ff + 3'd1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.issue) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         line_ff  <= line_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         caddr_ff <= caddr_in;
         paddr_ff <= paddr_in;
         row_ff   <= name_offset[9:5];
         col_ff   <= name_offset[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         vram_mem[wr_addr[VRAM_ADDR_W-1:0]] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         pat_ff      <= vram_mem[prd_addr[VRAM_ADDR_W-1:0]];
         clr_ff      <= vram_mem[crd_addr[VRAM_ADDR_W-1:0]];
         out_row_ff  <= {row_ff, line_ff};
         out_col_ff  <= {col_ff, 3'b000};
         out_last_ff <= status.line_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {expand_row(pat_ff, clr_ff), out_col_ff, out_row_ff};

endmodule

// ===== hdl/pattern_tile_line_renderer.sv =====
// Top level of the pattern tile line renderer.
// Usage:
//   req_* carries input words. req_tuser is the mode: 0 stores req byte into
//   video memory, 1 renders one 8x8 tile from the pattern and color tables.
//   rsp_* carries pixel rows, eight per render, rsp_tlast on the eighth.
//   csr_* writes the color table base (index 0) or pattern table base (1).
// Timing:
//   A store yields no word. A render is accepted while idle, then issues
//   one line read per cycle, while the receiver does not stall, from the
//   dual-read video memory; after acceptance the controller enters its run
//   state, and each line read is then registered into the output word.
//   The next word is taken once the eighth line read has been issued, while
//   the last row may still wait in the output register. A render holds the
//   input through the accept and the eight line reads.
// Reset clears control and the base registers; video memory is not cleared.
// A receiver stall holds the current row and pauses line reads; nothing is
// dropped.
module pattern_tile_line_renderer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [ptlr_pkg::ADDR_W-1:0]     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // vram_addr[16:0], write_byte[24:17], name_offset[34:25], char_code[42:35]
   input  logic [ptlr_pkg::IN_DATA_W-1:0]  req_tdata,
   // mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_row[7:0], pixel_col[15:8], pixels[47:16]
   output logic [ptlr_pkg::OUT_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import ptlr_pkg::*;

   cmd_type    cmd;
   status_type status;

   ptlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptlr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/ptlr_checker.sv =====
// Port-level checker for the tile line renderer, bound to the top level.
module ptlr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ptlr_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import ptlr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_RENDER |=> !req_tready)
      else $error("input taken right after a render word");

   a_store_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_STORE |=> req_tready)
      else $error("store word left block busy");

   a_mid_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open while a tile is still being emitted");

   a_col_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] == 3'b000)
      else $error("pixel column not tile aligned");

endmodule

bind pattern_tile_line_renderer ptlr_checker u_ptlr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
